### rtl/core/vdtb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vdtb_pkg;

  localparam int FRAC_W      = 32;
  localparam int SPEED_FRAC  = 30;
  localparam int DIV_W       = 76;
  localparam int DIV_CNT_W   = 7;
  localparam int ACC_W       = 96;

  localparam logic [31:0] HOST_FREQ_RST = 32'd1000000000;
  localparam logic [18:0] REFRESH_RST   = 19'd60000;
  localparam logic [31:0] SPEED_ONE     = 32'h4000_0000;

  // 1000 for millihertz, times 4 to move 30 speed fraction bits to 32
  localparam logic [DIV_W-1:0] IVL_SCALE = 76'd4000;

  // ceil(2^30 / 1000) and ceil(2^35 / 10), exact over the operand ranges used
  localparam logic [31:0] HZ_RECIP    = 32'd1073742;
  localparam logic [31:0] TENTH_RECIP = 32'd3435973837;

  typedef enum logic [1:0] {
    CMD_VBLANK = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_HOST_FREQ = 2'd0,
    REG_REFRESH   = 2'd1,
    REG_SPEED     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_IVL_M, ST_IVL_D, ST_IVL_W, ST_DISP,
    ST_HZ_D, ST_HZ_W, ST_STP_D, ST_STP_W, ST_DL_D, ST_DL_W,
    ST_CHK, ST_K_W, ST_T0, ST_T1, ST_T2,
    ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_A6,
    ST_INT, ST_E0, ST_E1, ST_E2, ST_E3, ST_FIN, ST_OUT
  } state_t;

endpackage
`default_nettype wire

### rtl/core/vblank_disciplined_timebase_unit.sv
// Vertical-blank disciplined timebase.
// Input stream: in_tuser carries the command (vblank report, query, start,
// stop), in_tdata the host time, blank count and interpolate flag. Every
// transfer on the input gives exactly one transfer on the output: the time
// value, mode flag, missed-blank total and effective speed.
// Configuration: cfg_we with cfg_index 0 host frequency, 1 refresh rate in
// millihertz, 2 for the clock speed; write only while the block is idle.
// Processing path: every item first passes through the 76-step bit-serial
// division that forms the blank interval; a report that advances the clock
// then adds the clock advance. A running query adds a 32-step division for
// the blank period and the multiplies, a 64-step division and the clock
// advance when blanks were missed, and the interpolation when it is asked
// for. One item is handled at a time; in_tready is high only while the
// sequencer is idle, so a new item is taken only after the last result has
// gone to the output register.
// A finished result waits in the output register; while the receiver
// stalls the next item is already taken, and its result waits for the
// register to free.
// Reset clears the clock state and loads the default configuration.
`timescale 1ns / 1ps
`default_nettype none
module vblank_disciplined_timebase_unit
  import vdtb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // host_time[62:0], vblank_count[70:63], interpolate[71]
  input  wire logic [71:0]  in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // time_value[63:0], vblank_mode[64], total_missed[96:65],
  // effective_speed[128:97], zero[135:129]
  output logic [135:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [31:0] hf_r, rr_cs_dummy;
  logic [18:0] rr_r;
  logic [31:0] cs_r, cs_nxt;

  logic [63:0] clk_r, clk_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic [63:0] lrep_r, lrep_nxt;
  logic [63:0] bts_r, bts_nxt;
  logic [15:0] mpend_r, mpend_nxt;
  logic [31:0] msum_r, msum_nxt;
  logic        run_r, run_nxt;
  logic [63:0] off_r, off_nxt;

  cmd_t        cmd_r, cmd_nxt;
  logic [62:0] now_r, now_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        interp_r, interp_nxt;

  logic [DIV_W-1:0] ivl_r, ivl_nxt;
  logic [9:0]       hz_r, hz_nxt;
  logic [31:0]      step_r, step_nxt;
  logic [32:0]      dl_r, dl_nxt;
  logic [63:0]      k_r, k_nxt;
  logic [63:0]      dv_r, dv_nxt;
  logic             neg_r, neg_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [63:0]      ans_r, ans_nxt;

  logic         ovalid_r, ovalid_nxt;
  logic [128:0] odata_r, odata_nxt;

  logic [31:0] mul_a, mul_b;

  div_req_t         dreq;
  logic [DIV_W-1:0] ddividend;
  logic [31:0]      ddivisor;
  logic             ddone;
  logic [DIV_W-1:0] dquot;

  logic [63:0] ivl_int;
  logic [31:0] ivl_frac;
  logic [63:0] d_now;
  logic [63:0] cap;
  logic [65:0] elap;
  logic [63:0] el, cand;
  logic [64:0] sum_p, sum_s;
  logic [28:0] tenth;
  logic [3:0]  step_rem;
  logic [3:0]  dl_frac;
  logic [32:0] dl_calc;

  assign rr_cs_dummy = '0;
  assign ivl_int  = {20'b0, ivl_r[DIV_W-1:FRAC_W]};
  assign ivl_frac = ivl_r[FRAC_W-1:0];
  assign d_now    = {1'b0, now_r} - bts_r;
  assign cap      = {ivl_int[62:0], 1'b0} + {63'b0, ivl_frac[31]};
  assign elap     = acc_r[ACC_W-1:SPEED_FRAC];
  assign el       = (elap[65:64] != 2'b0 || elap[63:0] > cap) ? cap : elap[63:0];
  assign cand     = neg_r ? clk_r - elap[63:0] : clk_r + el;
  assign sum_p    = {49'b0, mpend_r} + {1'b0, k_r};
  assign sum_s    = {33'b0, msum_r} + {1'b0, k_r};

  // deadline = 13 * (step / 10) + 13 * (step % 10) / 10
  assign tenth    = prod_r[63:35];
  assign step_rem = 4'(step_r - {tenth, 3'b0} - {2'b0, tenth, 1'b0});
  assign dl_calc  = {1'b0, tenth, 3'b0} + {2'b0, tenth, 2'b0} + {4'b0, tenth}
                  + {29'b0, dl_frac};

  always_comb begin
    case (step_rem)
      4'd1:    dl_frac = 4'd1;
      4'd2:    dl_frac = 4'd2;
      4'd3:    dl_frac = 4'd3;
      4'd4:    dl_frac = 4'd5;
      4'd5:    dl_frac = 4'd6;
      4'd6:    dl_frac = 4'd7;
      4'd7:    dl_frac = 4'd9;
      4'd8:    dl_frac = 4'd10;
      4'd9:    dl_frac = 4'd11;
      default: dl_frac = 4'd0;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'b0, odata_r};

  vdtb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .dividend (ddividend),
    .divisor  (ddivisor),
    .done     (ddone),
    .quotient (dquot)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_IVL_M: begin mul_a = cs_r;       mul_b = hf_r;     end
      ST_HZ_D:  begin mul_a = 32'({1'b0, rr_r} + 20'd500); mul_b = HZ_RECIP; end
      ST_DL_D:  begin mul_a = step_r;     mul_b = TENTH_RECIP; end
      ST_T0:    begin mul_a = k_r[31:0];  mul_b = step_r;   end
      ST_T1:    begin mul_a = k_r[63:32]; mul_b = step_r;   end
      ST_A0:    begin mul_a = k_r[31:0];  mul_b = ivl_frac; end
      ST_A1:    begin mul_a = k_r[63:32]; mul_b = ivl_frac; end
      ST_A3:    begin mul_a = k_r[31:0];  mul_b = ivl_int[31:0]; end
      ST_A4:    begin mul_a = k_r[31:0];  mul_b = ivl_int[63:32]; end
      ST_A5:    begin mul_a = k_r[63:32]; mul_b = ivl_int[31:0]; end
      ST_E0:    begin mul_a = dv_r[31:0];  mul_b = cs_r; end
      ST_E1:    begin mul_a = dv_r[63:32]; mul_b = cs_r; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_nxt = {32'b0, mul_a} * {32'b0, mul_b};

  always_comb begin
    state_nxt  = state_r;
    cs_nxt     = cs_r;
    clk_nxt    = clk_r;
    frac_nxt   = frac_r;
    lrep_nxt   = lrep_r;
    bts_nxt    = bts_r;
    mpend_nxt  = mpend_r;
    msum_nxt   = msum_r;
    run_nxt    = run_r;
    off_nxt    = off_r;
    cmd_nxt    = cmd_r;
    now_nxt    = now_r;
    cnt_nxt    = cnt_r;
    interp_nxt = interp_r;
    ivl_nxt    = ivl_r;
    hz_nxt     = hz_r;
    step_nxt   = step_r;
    dl_nxt     = dl_r;
    k_nxt      = k_r;
    dv_nxt     = dv_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    ans_nxt    = ans_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    dreq       = '0;
    ddividend  = '0;
    ddivisor   = 32'd1;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_SPEED: cs_nxt = cfg_wdata;
        default:   cs_nxt = cs_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = cmd_t'(in_tuser);
          now_nxt    = in_tdata[62:0];
          cnt_nxt    = in_tdata[70:63];
          interp_nxt = in_tdata[71];
          state_nxt  = ST_IVL_M;
        end
      end
      ST_IVL_M: state_nxt = ST_IVL_D;
      ST_IVL_D: begin
        dreq.start  = 1'b1;
        dreq.nbits  = DIV_CNT_W'(DIV_W);
        ddividend   = {12'b0, prod_r} * IVL_SCALE;
        ddivisor    = (rr_r == '0) ? 32'd1 : {13'b0, rr_r};
        state_nxt   = ST_IVL_W;
      end
      ST_IVL_W: begin
        if (ddone) begin
          ivl_nxt   = dquot;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        state_nxt = ST_FIN;
        unique case (cmd_r)
          CMD_VBLANK: begin
            if (run_r) begin
              bts_nxt   = {1'b0, now_r};
              mpend_nxt = '0;
              if ({8'b0, cnt_r} > mpend_r) begin
                k_nxt     = {48'b0, 16'({8'b0, cnt_r} - mpend_r)};
                state_nxt = ST_A0;
              end
            end
          end
          CMD_QUERY: begin
            if (run_r) begin
              state_nxt = ST_HZ_D;
            end else begin
              ans_nxt = {1'b0, now_r} + off_r;
            end
          end
          CMD_START: begin
            if (!run_r) begin
              clk_nxt   = {1'b0, now_r} + off_r;
              lrep_nxt  = {1'b0, now_r} + off_r;
              frac_nxt  = '0;
              cs_nxt    = SPEED_ONE;
              msum_nxt  = '0;
              mpend_nxt = '0;
              bts_nxt   = {1'b0, now_r};
              run_nxt   = 1'b1;
            end
          end
          CMD_STOP: begin
            if (run_r) begin
              run_nxt = 1'b0;
              off_nxt = clk_r - {1'b0, now_r};
            end
          end
        endcase
      end
      ST_HZ_D: state_nxt = ST_HZ_W;
      ST_HZ_W: begin
        hz_nxt    = (prod_r[39:30] == '0) ? 10'd1 : prod_r[39:30];
        state_nxt = ST_STP_D;
      end
      ST_STP_D: begin
        dreq.start = 1'b1;
        dreq.nbits = DIV_CNT_W'(32);
        ddividend  = {hf_r, 44'b0};
        ddivisor   = {22'b0, hz_r};
        state_nxt  = ST_STP_W;
      end
      ST_STP_W: begin
        if (ddone) begin
          step_nxt  = (dquot[31:0] == '0) ? 32'd1 : dquot[31:0];
          state_nxt = ST_DL_D;
        end
      end
      ST_DL_D: state_nxt = ST_DL_W;
      ST_DL_W: begin
        dl_nxt    = dl_calc;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (!d_now[63] && d_now >= {31'b0, dl_r}) begin
          dreq.start = 1'b1;
          dreq.nbits = DIV_CNT_W'(64);
          ddividend  = {d_now - {31'b0, dl_r}, 12'b0};
          ddivisor   = step_r;
          state_nxt  = ST_K_W;
        end else begin
          state_nxt = ST_INT;
        end
      end
      ST_K_W: begin
        if (ddone) begin
          k_nxt     = dquot[63:0] + 64'd1;
          state_nxt = ST_T0;
        end
      end
      ST_T0: begin
        acc_nxt   = {32'b0, bts_r};
        state_nxt = ST_T1;
      end
      ST_T1: begin
        acc_nxt   = acc_r + {32'b0, prod_r};
        state_nxt = ST_T2;
      end
      ST_T2: begin
        bts_nxt   = 64'(acc_r + {prod_r, 32'b0});
        mpend_nxt = (sum_p >= 65'hFFFF) ? 16'hFFFF : sum_p[15:0];
        msum_nxt  = (sum_s >= 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum_s[31:0];
        state_nxt = ST_A0;
      end
      ST_A0: begin
        acc_nxt   = {64'b0, frac_r};
        state_nxt = ST_A1;
      end
      ST_A1: begin
        acc_nxt   = acc_r + {32'b0, prod_r};
        state_nxt = ST_A2;
      end
      ST_A2: begin
        acc_nxt   = acc_r + {prod_r, 32'b0};
        state_nxt = ST_A3;
      end
      ST_A3: begin
        frac_nxt  = acc_r[FRAC_W-1:0];
        acc_nxt   = {32'b0, 64'(clk_r + acc_r[ACC_W-1:FRAC_W])};
        state_nxt = ST_A4;
      end
      ST_A4: begin
        acc_nxt   = acc_r + {32'b0, prod_r};
        state_nxt = ST_A5;
      end
      ST_A5: begin
        acc_nxt   = acc_r + {prod_r, 32'b0};
        state_nxt = ST_A6;
      end
      ST_A6: begin
        clk_nxt   = 64'(acc_r + {prod_r, 32'b0});
        state_nxt = (cmd_r == CMD_QUERY) ? ST_INT : ST_FIN;
      end
      ST_INT: begin
        if (interp_r) begin
          neg_nxt   = d_now[63];
          dv_nxt    = d_now[63] ? 64'(-d_now) : d_now;
          state_nxt = ST_E0;
        end else begin
          ans_nxt   = clk_r;
          state_nxt = ST_FIN;
        end
      end
      ST_E0: state_nxt = ST_E1;
      ST_E1: begin
        acc_nxt   = {32'b0, prod_r};
        state_nxt = ST_E2;
      end
      ST_E2: begin
        acc_nxt   = acc_r + {prod_r, 32'b0};
        state_nxt = ST_E3;
      end
      ST_E3: begin
        if ($signed(cand) > $signed(lrep_r)) begin
          lrep_nxt = cand;
          ans_nxt  = cand;
        end else begin
          ans_nxt  = lrep_r;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (cmd_r != CMD_QUERY) begin
          ans_nxt = clk_r;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {run_r ? cs_r : SPEED_ONE, msum_r, run_r, ans_r};
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hf_r     <= HOST_FREQ_RST;
      rr_r     <= REFRESH_RST;
      cs_r     <= SPEED_ONE;
      clk_r    <= '0;
      frac_r   <= '0;
      lrep_r   <= '0;
      bts_r    <= '0;
      mpend_r  <= '0;
      msum_r   <= '0;
      run_r    <= 1'b0;
      off_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cs_r     <= cs_nxt;
      clk_r    <= clk_nxt;
      frac_r   <= frac_nxt;
      lrep_r   <= lrep_nxt;
      bts_r    <= bts_nxt;
      mpend_r  <= mpend_nxt;
      msum_r   <= msum_nxt;
      run_r    <= run_nxt;
      off_r    <= off_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_HOST_FREQ: hf_r <= cfg_wdata | rr_cs_dummy;
          REG_REFRESH:   rr_r <= cfg_wdata[18:0];
          default:       hf_r <= hf_r;
        endcase
      end
    end
    cmd_r    <= cmd_nxt;
    now_r    <= now_nxt;
    cnt_r    <= cnt_nxt;
    interp_r <= interp_nxt;
    ivl_r    <= ivl_nxt;
    hz_r     <= hz_nxt;
    step_r   <= step_nxt;
    dl_r     <= dl_nxt;
    k_r      <= k_nxt;
    dv_r     <= dv_nxt;
    neg_r    <= neg_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    ans_r    <= ans_nxt;
    odata_r  <= odata_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/vdtb_div.sv
`timescale 1ns / 1ps
`default_nettype none
module vdtb_div
  import vdtb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire div_req_t         req,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [31:0]      divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [31:0]          dvs_r, dvs_nxt;
  logic [32:0]          rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r, q_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(rem_sh - {1'b0, dvs_r}) : rem_sh[31:0];
      q_nxt   = {q_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire
